/* hw/rtl/cev_pkg.sv */
`default_nettype none

package cev_pkg;

    localparam int unsigned CNT_W = 17;

    localparam logic [15:0]      CRC_INIT       = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY       = 16'h1021;
    localparam logic [15:0]      CRC_TOP        = 16'h8000;
    localparam logic [CNT_W-1:0] FRAME_OVERHEAD = CNT_W'(9);
    localparam logic [CNT_W-1:0] COUNT_MAX      = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TRUNC   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_CRC     = 3'd5
    } t_status;

    typedef enum logic {
        REG_MAGIC   = 1'b0,
        REG_VERSION = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  expected_version;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [15:0] body_length;
    } t_result;

    // One byte of CRC-16/CCITT, MSB first, no reflection.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cev_if.sv */
`default_nettype none

interface cev_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cev_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] body_length;

    modport source (output valid, output status, output body_length, input ready);
    modport sink   (input valid, input status, input body_length, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cev_cfg.sv */
`default_nettype none

module cev_cfg import cev_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [31:0] r_magic;
    logic [7:0]  r_version;
    t_reg_idx    reg_idx;
    logic        wr_en;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= '0;
            r_version <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MAGIC:   r_magic   <= pwdata;
                REG_VERSION: r_version <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAGIC:   prdata = r_magic;
            REG_VERSION: prdata = {24'h000000, r_version};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.magic_word       = r_magic;
    assign o_cfg.expected_version = r_version;

endmodule

`default_nettype wire

/* hw/rtl/cev_frame.sv */
`default_nettype none

module cev_frame import cev_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output logic            o_ready,
    input  wire logic       i_slot_free,
    output t_result         o_res
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    logic [CNT_W-1:0] r_count;
    logic [15:0]      r_crc;
    logic [7:0]       r_d0;
    logic [7:0]       r_d1;
    logic             r_magic_ok;
    logic             r_version_ok;
    logic [15:0]      r_body;

    logic             n_magic_ok;
    logic             n_version_ok;
    logic [15:0]      n_body;
    logic [15:0]      n_crc;
    logic [7:0]       magic_byte;
    logic             sat;
    logic             advance;
    logic             accept;
    logic [15:0]      rx_crc;
    t_status          status;

    assign advance = r_in_valid && (!r_in_last || i_slot_free);
    assign o_ready = !r_in_valid || advance;
    assign accept  = i_valid && o_ready;
    assign sat     = (r_count == COUNT_MAX);

    always_comb begin
        case (r_count[1:0])
            2'd0:    magic_byte = i_cfg.magic_word[7:0];
            2'd1:    magic_byte = i_cfg.magic_word[15:8];
            2'd2:    magic_byte = i_cfg.magic_word[23:16];
            default: magic_byte = i_cfg.magic_word[31:24];
        endcase
    end

    always_comb begin
        n_magic_ok   = r_magic_ok;
        n_version_ok = r_version_ok;
        n_body       = r_body;
        if (r_count < CNT_W'(4)) begin
            if (magic_byte != r_in_byte) begin
                n_magic_ok = 1'b0;
            end
        end else if (r_count == CNT_W'(4)) begin
            n_version_ok = (r_in_byte == i_cfg.expected_version);
        end else if (r_count == CNT_W'(5)) begin
            n_body = {r_body[15:8], r_in_byte};
        end else if (r_count == CNT_W'(6)) begin
            n_body = {r_in_byte, r_body[7:0]};
        end
        // two-byte delay keeps the trailing checksum out of the CRC
        n_crc = (r_count >= CNT_W'(2)) ? crc_feed(r_crc, r_d0) : r_crc;
    end

    assign rx_crc = {r_in_byte, r_d1};

    always_comb begin
        if (!sat && r_count < CNT_W'(8)) begin
            status = ST_TRUNC;
        end else if (!n_magic_ok) begin
            status = ST_MAGIC;
        end else if (!n_version_ok) begin
            status = ST_VERSION;
        end else if (sat || (r_count + CNT_W'(1)) != (CNT_W'(n_body) + FRAME_OVERHEAD)) begin
            status = ST_LENGTH;
        end else if (n_crc != rx_crc) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end
    end

    assign o_res.valid       = advance && r_in_last;
    assign o_res.status      = status;
    assign o_res.body_length = (status == ST_TRUNC) ? 16'h0000 : n_body;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_count      <= '0;
            r_crc        <= CRC_INIT;
            r_d0         <= '0;
            r_d1         <= '0;
            r_magic_ok   <= 1'b1;
            r_version_ok <= 1'b0;
            r_body       <= '0;
        end else if (advance) begin
            r_count      <= sat ? r_count : r_count + CNT_W'(1);
            r_crc        <= n_crc;
            r_d0         <= r_d1;
            r_d1         <= r_in_byte;
            r_magic_ok   <= n_magic_ok;
            r_version_ok <= n_version_ok;
            r_body       <= n_body;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |=> (r_count == '0 && r_crc == CRC_INIT))
        else $error("frame state not cleared after result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_last && !sat) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("byte count did not advance");

    a_crc_held_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < CNT_W'(2)) |-> (r_crc == CRC_INIT))
        else $error("CRC moved before delay line filled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_ready)
        else $error("empty input stage not ready");
`endif

endmodule

`default_nettype wire

/* hw/rtl/crc_envelope_validator.sv */
`default_nettype none

// Channel   Dir  Word
// i_in      in   data_byte[7:0], last_byte
// o_out     out  status[2:0], body_length[15:0]
// apb       in   magic_word @0x0, expected_version @0x4
//
// One byte per cycle sustained; a frame's result passes the input register,
// then the result register, after its final byte is taken. Byte-wide CRC
// update sits between the two. Synchronous active-low reset clears the frame
// state and the valid flags of both registers. A stalled result blocks only a
// final byte; other bytes keep flowing while the result waits.

module crc_envelope_validator import cev_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cev_in_if.sink           i_in,
    cev_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg        cfg;
    t_result     res;
    logic        slot_free;
    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [15:0] r_out_body;

    cev_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cev_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_in.valid),
        .i_byte      (i_in.data_byte),
        .i_last      (i_in.last_byte),
        .o_ready     (i_in.ready),
        .i_slot_free (slot_free),
        .o_res       (res)
    );

    assign slot_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_status <= res.status;
            r_out_body   <= res.body_length;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.body_length = r_out_body;

endmodule

`default_nettype wire
